@@ src/wsd_pkg.sv @@
// Package: shared types, constants and type decode for the wiggle section decoder.
`default_nettype none
package wsd_pkg;

    localparam logic [7:0] TYPE_BEDGRAPH  = 8'd1;
    localparam logic [7:0] TYPE_VARSTEP   = 8'd2;
    localparam logic [7:0] TYPE_FIXEDSTEP = 8'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_QUERY_START  = 2'd0;
    localparam logic [1:0] REG_QUERY_END    = 2'd1;
    localparam logic [1:0] REG_BYTE_SWAPPED = 2'd2;

    typedef enum logic [1:0] {
        KC_NONE  = 2'd0,
        KC_BED   = 2'd1,
        KC_VAR   = 2'd2,
        KC_FIXED = 2'd3
    } kind_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       section_begin;
    } in_word_t;

    typedef struct packed {
        logic [31:0] iv_start;
        logic [31:0] iv_end;
        logic [31:0] value_bits;
        logic        kept;
        logic        bad_type;
        logic        last_of_section;
    } out_word_t;

    // decoded item passed from front to back, before clipping
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] stop;
        logic [31:0] value;
        logic        last;
        logic        bad;
    } item_rec_t;

    typedef struct packed {
        logic [31:0] query_start;
        logic [31:0] query_end;
    } clip_cfg_t;

    function automatic kind_class_t kind_class(input logic [7:0] kind);
        kind_class_t k;
        if (kind == TYPE_BEDGRAPH) begin
            k = KC_BED;
        end else if (kind == TYPE_VARSTEP) begin
            k = KC_VAR;
        end else if (kind == TYPE_FIXEDSTEP) begin
            k = KC_FIXED;
        end else begin
            k = KC_NONE;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

@@ src/wiggle_section_decoder.sv @@
// Top level: wiggle data section decoder with APB register port.
//
// s_ channel: one section byte per word; section_begin marks header byte 0.
// The 24-byte header (chrom id, start, end, step, span, type, reserved,
// item count) is parsed, then items are decoded by type (bedGraph,
// variableStep, fixedStep). Each completed item gives one m_ word with the
// interval clipped to [query_start, query_end) and a kept flag; an unknown
// type gives one word with bad_type and last_of_section set.
// Throughput: one byte per cycle while the queue is not full. The front decode
// writes an item's record into the 4-entry record queue when the byte that
// completes it is taken; the clip stage then moves it into the output register.
// When m_ready is low the queue absorbs up to 4 results; s_ready drops
// only while the queue is full.
// Registers (APB, 4-byte stride): query_start, query_end, byte_swapped.
// Write them only while no section is in flight. Reset empties the queue,
// idles the parser and sets query_start 0, query_end all ones, little-endian.
`default_nettype none
module wiggle_section_decoder import wsd_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [31:0] qstart_reg;
    logic [31:0] qend_reg;
    logic        swap_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    clip_cfg_t   clip_cfg;
    item_rec_t   front_rec, head_rec;
    logic        front_push, q_full, q_not_empty, q_pop, in_fire;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qstart_reg <= '0;
            qend_reg   <= '1;
            swap_reg   <= 1'b0;
        end else if (wr_en) begin
            priority case (reg_sel)
                REG_QUERY_START:  qstart_reg <= pwdata;
                REG_QUERY_END:    qend_reg   <= pwdata;
                REG_BYTE_SWAPPED: swap_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_QUERY_START:  prdata = qstart_reg;
            REG_QUERY_END:    prdata = qend_reg;
            REG_BYTE_SWAPPED: prdata = {31'd0, swap_reg};
            default:          prdata = '0;
        endcase
    end

    assign clip_cfg.query_start = qstart_reg;
    assign clip_cfg.query_end   = qend_reg;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    wsd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_swapped (swap_reg),
        .in_fire      (in_fire),
        .in_word      (s_data),
        .rec          (front_rec),
        .rec_push     (front_push)
    );

    wsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_rec  (front_rec),
        .pop       (q_pop),
        .head_rec  (head_rec),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    wsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clip_cfg   (clip_cfg),
        .head_rec   (head_rec),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

@@ src/wsd_front.sv @@
// Front end: parses section header bytes and item bytes into item records.
`default_nettype none
module wsd_front import wsd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      byte_swapped,
    input  wire logic      in_fire,
    input  wire in_word_t  in_word,
    output item_rec_t      rec,
    output logic           rec_push
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_HEADER = 3'b010,
        ST_ITEMS  = 3'b100
    } fstate_t;

    localparam logic [4:0] POS_START = 5'd7;
    localparam logic [4:0] POS_STEP  = 5'd15;
    localparam logic [4:0] POS_SPAN  = 5'd19;
    localparam logic [4:0] POS_KIND  = 5'd20;
    localparam logic [4:0] POS_HLAST = 5'd23;
    localparam logic [4:0] POS_WORD0 = 5'd3;
    localparam logic [4:0] POS_WORD1 = 5'd7;
    localparam logic [4:0] POS_BLAST = 5'd11;

    fstate_t     state_reg, state_next;
    logic [4:0]  idx_reg, idx_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] hstart_reg, hstart_next;
    logic [31:0] hstep_reg, hstep_next;
    logic [31:0] hspan_reg, hspan_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] left_reg, left_next;
    logic [31:0] shold_reg, shold_next;
    logic [31:0] ehold_reg, ehold_next;

    logic [31:0] gathered;
    logic [4:0]  pos;
    logic [4:0]  last_pos;
    logic [15:0] count_word;
    kind_class_t kc;

    assign pos = in_word.section_begin ? 5'd0 : idx_reg;
    assign gathered = byte_swapped ? {gather_reg[23:0], in_word.data_byte}
                                   : {in_word.data_byte, gather_reg[31:8]};
    assign count_word = byte_swapped ? gathered[15:0] : gathered[31:16];
    assign kc = kind_class(kind_reg);

    always_comb begin
        unique case (kc)
            KC_BED:  last_pos = POS_BLAST;
            KC_VAR:  last_pos = POS_WORD1;
            default: last_pos = POS_WORD0;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        gather_next = gather_reg;
        hstart_next = hstart_reg;
        hstep_next  = hstep_reg;
        hspan_next  = hspan_reg;
        kind_next   = kind_reg;
        left_next   = left_reg;
        shold_next  = shold_reg;
        ehold_next  = ehold_reg;
        rec_push    = 1'b0;
        rec         = '0;
        if (in_fire) begin
            if (in_word.section_begin || state_reg == ST_HEADER) begin
                gather_next = gathered;
                if (pos == POS_START) begin
                    hstart_next = gathered;
                end else if (pos == POS_STEP) begin
                    hstep_next = gathered;
                end else if (pos == POS_SPAN) begin
                    hspan_next = gathered;
                end else if (pos == POS_KIND) begin
                    kind_next = in_word.data_byte;
                end
                if (pos < POS_HLAST) begin
                    idx_next   = pos + 5'd1;
                    state_next = ST_HEADER;
                end else begin
                    idx_next  = '0;
                    left_next = count_word;
                    if (kc == KC_NONE) begin
                        state_next = ST_IDLE;
                        rec_push   = 1'b1;
                        rec.bad    = 1'b1;
                        rec.last   = 1'b1;
                    end else if (count_word == 16'd0) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ITEMS;
                        if (kc == KC_FIXED) begin
                            shold_next = hstart_reg;
                            ehold_next = hstart_reg + hspan_reg;
                        end
                    end
                end
            end else if (state_reg == ST_ITEMS) begin
                if (kc == KC_NONE) begin
                    state_next = ST_IDLE;
                end else begin
                    gather_next = gathered;
                    if (pos == POS_WORD0 && kc != KC_FIXED) begin
                        shold_next = gathered;
                        if (kc == KC_VAR) begin
                            ehold_next = gathered + hspan_reg;
                        end
                    end else if (pos == POS_WORD1 && kc == KC_BED) begin
                        ehold_next = gathered;
                    end
                    if (pos < last_pos) begin
                        idx_next = pos + 5'd1;
                    end else begin
                        idx_next   = '0;
                        rec_push   = 1'b1;
                        rec.start  = shold_reg;
                        rec.stop   = ehold_reg;
                        rec.value  = gathered;
                        rec.last   = (left_reg == 16'd1);
                        left_next  = left_reg - 16'd1;
                        if (kc == KC_FIXED) begin
                            shold_next = shold_reg + hstep_reg;
                            ehold_next = ehold_reg + hstep_reg;
                        end
                        if (left_reg == 16'd1) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            gather_reg <= '0;
            hstart_reg <= '0;
            hstep_reg  <= '0;
            hspan_reg  <= '0;
            kind_reg   <= '0;
            left_reg   <= '0;
            shold_reg  <= '0;
            ehold_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            gather_reg <= gather_next;
            hstart_reg <= hstart_next;
            hstep_reg  <= hstep_next;
            hspan_reg  <= hspan_next;
            kind_reg   <= kind_next;
            left_reg   <= left_next;
            shold_reg  <= shold_next;
            ehold_reg  <= ehold_next;
        end
    end

endmodule
`default_nettype wire

@@ src/wsd_queue.sv @@
// Short queue of decoded item records between front and back.
`default_nettype none
module wsd_queue import wsd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire item_rec_t push_rec,
    input  wire logic      pop,
    output item_rec_t      head_rec,
    output logic           not_empty,
    output logic           full
);

    item_rec_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_rec  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/wsd_back.sv @@
// Back end: clips item records to the query range and holds the output word.
`default_nettype none
module wsd_back import wsd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire clip_cfg_t clip_cfg,
    input  wire item_rec_t head_rec,
    input  wire logic      head_valid,
    output logic           pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    logic      valid_reg;
    out_word_t data_reg, data_next;
    logic [31:0] cs, ce;

    assign pop = head_valid && (!valid_reg || m_ready);

    always_comb begin
        cs = (head_rec.start < clip_cfg.query_start) ? clip_cfg.query_start : head_rec.start;
        ce = (head_rec.stop > clip_cfg.query_end) ? clip_cfg.query_end : head_rec.stop;
        data_next = '0;
        if (head_rec.bad) begin
            data_next.bad_type        = 1'b1;
            data_next.last_of_section = 1'b1;
        end else begin
            data_next.iv_start        = cs;
            data_next.iv_end          = ce;
            data_next.value_bits      = head_rec.value;
            data_next.kept            = (cs < ce);
            data_next.last_of_section = head_rec.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
`default_nettype wire

@@ verif/tb_wiggle_section_decoder.sv @@
`timescale 1ns / 100ps
// Testbench: byte-stream sections through the decoder, results checked against a local decode.
module tb_wiggle_section_decoder;
    import wsd_pkg::*;

    typedef struct {
        logic [7:0]  kind;
        logic [15:0] count;
        logic [31:0] start;
        logic [31:0] step;
        logic [31:0] span;
        logic [31:0] qs;
        logic [31:0] qe;
        logic        swap;
        int          cut;
        int          noise;
        bit          rand_items;
        bit          typed_on;
        out_word_t   typed;
    } section_t;

    localparam out_word_t BAD_WORD   = {96'd0, 3'b011};
    localparam int        RAND_WORDS = 1100;
    localparam int        PLAN_LEN   = 14;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // local decoder state and register copy
    logic [4:0]  dec_index;
    logic [31:0] dec_gather;
    logic [31:0] dec_hstart;
    logic [31:0] dec_hstep;
    logic [31:0] dec_hspan;
    logic [7:0]  dec_kind;
    logic [15:0] dec_left;
    logic [31:0] dec_start;
    logic [31:0] dec_end;
    logic        dec_items;
    logic        dec_header;
    logic [31:0] cfg_qs;
    logic [31:0] cfg_qe;
    logic        cfg_swap;

    out_word_t   due_words[$];
    out_word_t   due_word;
    out_word_t   pred_word;
    bit          pred_hit;
    logic [7:0]  sect_bytes[$];
    section_t    plan[PLAN_LEN];
    int          mismatches  = 0;
    int          bytes_taken = 0;
    int          idle_pct    = 20;
    int          ready_pct   = 20;
    bit          calm;
    bit          hold_req;
    bit          hold_done;
    bit          cur_typed_on;
    out_word_t   cur_typed;

    wiggle_section_decoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic kind_class_t classify_kind(input logic [7:0] kind);
        case (kind)
            TYPE_BEDGRAPH:  return KC_BED;
            TYPE_VARSTEP:   return KC_VAR;
            TYPE_FIXEDSTEP: return KC_FIXED;
            default:        return KC_NONE;
        endcase
    endfunction

    function automatic bit decode_byte(input in_word_t w, output out_word_t r);
        logic [4:0]  pos;
        logic [4:0]  last_pos;
        kind_class_t k;
        r = '0;
        if (w.section_begin) begin
            dec_header = 1'b1;
            dec_items  = 1'b0;
            dec_index  = '0;
        end
        if (dec_header) begin
            pos = dec_index;
            dec_gather = cfg_swap ? {dec_gather[23:0], w.data_byte}
                                  : {w.data_byte, dec_gather[31:8]};
            case (pos)
                5'd7:  dec_hstart = dec_gather;
                5'd15: dec_hstep  = dec_gather;
                5'd19: dec_hspan  = dec_gather;
                5'd20: dec_kind   = w.data_byte;
                default: ;
            endcase
            if (pos < 5'd23) begin
                dec_index = pos + 5'd1;
                return 1'b0;
            end
            dec_header = 1'b0;
            dec_index  = '0;
            dec_left   = cfg_swap ? dec_gather[15:0] : dec_gather[31:16];
            k = classify_kind(dec_kind);
            if (k == KC_NONE) begin
                dec_items         = 1'b0;
                r.bad_type        = 1'b1;
                r.last_of_section = 1'b1;
                return 1'b1;
            end
            if (dec_left == 16'd0) begin
                dec_items = 1'b0;
                return 1'b0;
            end
            dec_items = 1'b1;
            if (k == KC_FIXED) begin
                dec_start = dec_hstart;
                dec_end   = dec_hstart + dec_hspan;
            end
            return 1'b0;
        end
        if (dec_items) begin
            k = classify_kind(dec_kind);
            pos = dec_index;
            last_pos = (k == KC_BED) ? 5'd11 : (k == KC_VAR) ? 5'd7 : 5'd3;
            if (k == KC_NONE) begin
                dec_items = 1'b0;
                return 1'b0;
            end
            dec_gather = cfg_swap ? {dec_gather[23:0], w.data_byte}
                                  : {w.data_byte, dec_gather[31:8]};
            if (pos == 5'd3 && k != KC_FIXED) begin
                dec_start = dec_gather;
                if (k == KC_VAR) dec_end = dec_gather + dec_hspan;
            end else if (pos == 5'd7 && k == KC_BED) begin
                dec_end = dec_gather;
            end
            if (pos < last_pos) begin
                dec_index = pos + 5'd1;
                return 1'b0;
            end
            dec_index         = '0;
            r.iv_start        = (dec_start < cfg_qs) ? cfg_qs : dec_start;
            r.iv_end          = (dec_end > cfg_qe) ? cfg_qe : dec_end;
            r.value_bits      = dec_gather;
            r.kept            = r.iv_start < r.iv_end;
            r.last_of_section = dec_left == 16'd1;
            dec_left          = dec_left - 16'd1;
            if (k == KC_FIXED) begin
                dec_start = dec_start + dec_hstep;
                dec_end   = dec_end + dec_hstep;
            end
            if (dec_left == 16'd0) dec_items = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                bytes_taken++;
                pred_hit = decode_byte(s_data, pred_word);
                if (pred_hit || cur_typed_on)
                    due_words.push_back(cur_typed_on ? cur_typed : pred_word);
            end
            if (m_valid && m_ready) begin
                if (due_words.size() == 0) begin
                    flag_error($sformatf("word with none due: %h", m_data));
                end else begin
                    due_word = due_words.pop_front();
                    if (m_data.iv_start !== due_word.iv_start)
                        flag_error($sformatf("iv_start %h, due %h",
                                             m_data.iv_start, due_word.iv_start));
                    if (m_data.iv_end !== due_word.iv_end)
                        flag_error($sformatf("iv_end %h, due %h",
                                             m_data.iv_end, due_word.iv_end));
                    if (m_data.value_bits !== due_word.value_bits)
                        flag_error($sformatf("value_bits %h, due %h",
                                             m_data.value_bits, due_word.value_bits));
                    if (m_data.kept !== due_word.kept)
                        flag_error($sformatf("kept %b, due %b",
                                             m_data.kept, due_word.kept));
                    if (m_data.bad_type !== due_word.bad_type)
                        flag_error($sformatf("bad_type %b, due %b",
                                             m_data.bad_type, due_word.bad_type));
                    if (m_data.last_of_section !== due_word.last_of_section)
                        flag_error($sformatf("last_of_section %b, due %b",
                                             m_data.last_of_section,
                                             due_word.last_of_section));
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (250) @(negedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < ready_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input in_word_t w, input bit typed_on, input out_word_t typed);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data       <= w;
        cur_typed_on <= typed_on;
        cur_typed    <= typed;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_QUERY_START:  cfg_qs   = val;
            REG_QUERY_END:    cfg_qe   = val;
            REG_BYTE_SWAPPED: cfg_swap = val[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_query(input logic [31:0] qs, input logic [31:0] qe, input logic swap);
        drain();
        write_reg(REG_QUERY_START, qs);
        write_reg(REG_QUERY_END, qe);
        write_reg(REG_BYTE_SWAPPED, {31'd0, swap});
    endtask

    function automatic void put_field(input logic [31:0] v, input int n);
        for (int j = 0; j < n; j++)
            sect_bytes.push_back(cfg_swap ? v[8*(n-1-j) +: 8] : v[8*j +: 8]);
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return cfg_qs + $urandom_range(0, 64) - 32;
            2:       return cfg_qe + $urandom_range(0, 64) - 32;
            3:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom_range(0, 100000);
        endcase
    endfunction

    task automatic send_section(input section_t r);
        kind_class_t k;
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] v;
        in_word_t    w;
        int          lim;
        int          n;
        k = classify_kind(r.kind);
        lim = (r.cut > 0) ? r.cut : 32'h7FFF_FFFF;
        sect_bytes.delete();
        put_field($urandom, 4);
        put_field(r.start, 4);
        put_field($urandom, 4);
        put_field(r.step, 4);
        put_field(r.span, 4);
        sect_bytes.push_back(r.kind);
        sect_bytes.push_back(8'($urandom));
        put_field({16'd0, r.count}, 2);
        if (k != KC_NONE) begin
            for (int i = 0; i < int'(r.count) && sect_bytes.size() < lim; i++) begin
                if (r.rand_items) begin
                    s = pick_pos();
                    e = ($urandom_range(0, 3) == 0) ? $urandom : s + $urandom_range(0, 800);
                    v = $urandom;
                end else begin
                    s = r.start + i * r.step;
                    e = s + r.span;
                    v = 32'h3F80_0000 + i;
                end
                if (k != KC_FIXED) put_field(s, 4);
                if (k == KC_BED) put_field(e, 4);
                put_field(v, 4);
            end
        end
        n = sect_bytes.size();
        if (r.cut > 0 && r.cut < n) n = r.cut;
        for (int j = 0; j < n; j++) begin
            w.data_byte     = sect_bytes[j];
            w.section_begin = (j == 0);
            send_word(w, r.typed_on && j == n - 1, r.typed);
        end
        for (int j = 0; j < r.noise; j++) begin
            w.data_byte     = 8'($urandom);
            w.section_begin = 1'b0;
            send_word(w, 1'b0, '0);
        end
    endtask

    function automatic void build_random(output section_t r);
        int pick;
        pick = $urandom_range(0, 9);
        r.kind = (pick < 3) ? TYPE_BEDGRAPH : (pick < 6) ? TYPE_VARSTEP :
                 (pick < 9) ? TYPE_FIXEDSTEP : 8'($urandom);
        if (pick == 9 && classify_kind(r.kind) != KC_NONE) r.kind = ~r.kind;
        r.count = 16'($urandom_range(1, 6));
        r.cut   = 0;
        case ($urandom_range(0, 11))
            0: r.count = 16'd0;
            1: begin
                r.count = 16'($urandom);
                r.cut   = 24 + $urandom_range(0, 40);
            end
            2: r.cut = $urandom_range(1, 60);
            default: ;
        endcase
        r.start      = pick_pos();
        r.step       = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
        r.span       = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
        r.qs         = cfg_qs;
        r.qe         = cfg_qe;
        r.swap       = cfg_swap;
        r.noise      = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        r.rand_items = 1'b1;
        r.typed_on   = 1'b0;
        r.typed      = '0;
    endfunction

    initial begin
        section_t    row;
        int          rand_goal;
        logic [31:0] qs;
        logic [31:0] qe;
        s_valid      = 1'b0;
        s_data       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cur_typed_on = 1'b0;
        cur_typed    = '0;
        cfg_qs       = 32'd0;
        cfg_qe       = 32'hFFFF_FFFF;
        cfg_swap     = 1'b0;
        dec_index    = '0;
        dec_gather   = '0;
        dec_hstart   = '0;
        dec_hstep    = '0;
        dec_hspan    = '0;
        dec_kind     = '0;
        dec_left     = '0;
        dec_start    = '0;
        dec_end      = '0;
        dec_items    = 1'b0;
        dec_header   = 1'b0;
        aresetn      = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed sections: kind, count, start, step, span, qs, qe, swap,
        // cut, noise, rand_items, typed_on, typed
        plan[0]  = '{TYPE_BEDGRAPH, 16'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 0, 0, 1'b0, 1'b1,
                     {32'd0, 32'hFFFF_FFFF, 32'h3F80_0000, 3'b101}};
        plan[1]  = '{8'h00, 16'd5, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 0, 3, 1'b0, 1'b1, BAD_WORD};
        plan[2]  = '{8'hFF, 16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 0, 0, 1'b0, 1'b1, BAD_WORD};
        plan[3]  = '{8'h04, 16'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
                     1'b1, 0, 0, 1'b0, 1'b1, BAD_WORD};
        plan[4]  = '{TYPE_BEDGRAPH, 16'd3, 32'd100, 32'd50, 32'd30, 32'd120, 32'd190,
                     1'b1, 0, 0, 1'b0, 1'b0, '0};
        plan[5]  = '{TYPE_VARSTEP, 16'd4, 32'hFFFF_FFF0, 32'd8, 32'd20, 32'd0, 32'hFFFF_FFFF,
                     1'b1, 0, 0, 1'b0, 1'b0, '0};
        plan[6]  = '{TYPE_FIXEDSTEP, 16'd5, 32'hFFFF_FFE0, 32'd10, 32'd10, 32'hFFFF_FFE5,
                     32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b0, '0};
        plan[7]  = '{TYPE_FIXEDSTEP, 16'd0, 32'd5, 32'd5, 32'd5, 32'hFFFF_FFE5,
                     32'hFFFF_FFFF, 1'b0, 0, 3, 1'b0, 1'b0, '0};
        plan[8]  = '{TYPE_BEDGRAPH, 16'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b1,
                     {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000, 3'b001}};
        plan[9]  = '{TYPE_VARSTEP, 16'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0,
                     1'b0, 0, 0, 1'b0, 1'b1, {32'd0, 32'd0, 32'h3F80_0000, 3'b001}};
        plan[10] = '{TYPE_BEDGRAPH, 16'd4, 32'd10, 32'd10, 32'd5, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 10, 0, 1'b0, 1'b0, '0};
        plan[11] = '{TYPE_FIXEDSTEP, 16'd6, 32'd1000, 32'd100, 32'd40, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 33, 5, 1'b0, 1'b0, '0};
        plan[12] = '{TYPE_VARSTEP, 16'hFFFF, 32'd7, 32'd3, 32'd2, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 50, 0, 1'b0, 1'b0, '0};
        plan[13] = '{TYPE_BEDGRAPH, 16'd2, 32'd500, 32'd1000, 32'd600, 32'd0, 32'hFFFF_FFFF,
                     1'b0, 0, 6, 1'b0, 1'b0, '0};

        foreach (plan[i]) begin
            if (plan[i].qs != cfg_qs || plan[i].qe != cfg_qe || plan[i].swap != cfg_swap)
                set_query(plan[i].qs, plan[i].qe, plan[i].swap);
            send_section(plan[i]);
        end

        rand_goal = bytes_taken + RAND_WORDS;
        drain();
        // long receiver hold-off while a long fixedStep section keeps coming
        build_random(row);
        row.kind  = TYPE_FIXEDSTEP;
        row.count = 16'd32;
        row.cut   = 0;
        hold_req  = 1'b1;
        send_section(row);

        while (bytes_taken < rand_goal) begin
            case ($urandom_range(0, 5))
                0: begin qs = 32'd0;        qe = 32'hFFFF_FFFF; end
                1: begin qs = $urandom;     qe = qs + $urandom_range(0, 5000); end
                2: begin qs = 32'hFFFF_FFFF; qe = 32'hFFFF_FFFF; end
                3: begin qs = 32'd0;        qe = 32'd0; end
                4: begin qs = $urandom;     qe = $urandom; end
                default: begin
                    qs = $urandom_range(0, 1000);
                    qe = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                end
            endcase
            set_query(qs, qe, 1'($urandom_range(0, 1)));
            if (!calm) begin
                idle_pct  = 10 * $urandom_range(0, 3);
                ready_pct = 10 * $urandom_range(0, 3);
            end
            repeat ($urandom_range(3, 9)) begin
                build_random(row);
                send_section(row);
                if (bytes_taken + 300 > rand_goal) begin
                    calm      = 1'b1;
                    idle_pct  = 0;
                    ready_pct = 0;
                end
            end
            // close the phase on a whole section so the block is idle
            build_random(row);
            row.cut = 0;
            if (row.count > 16'd8) row.count = 16'd8;
            send_section(row);
        end

        drain();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
